[rtl/jdv_pkg.sv]
package jdv_pkg;

    typedef enum logic [4:0] {
        M_VALUE, M_OPEN_OBJ, M_OPEN_ARR, M_KEY, M_COLON, M_AFTER, M_DONE, M_ERROR,
        M_STR, M_ESC, M_HEX, M_LO_BS, M_LO_U, M_LO_HEX, M_UTF8,
        N_SIGN, N_ZERO, N_INT, N_DOT, N_FRAC, N_EXP, N_EXPSIGN, N_EXPDIG, M_LIT
    } mode_t;

    localparam logic [1:0] ST_VALID  = 2'd0;
    localparam logic [1:0] ST_SYNTAX = 2'd1;
    localparam logic [1:0] ST_DEPTH  = 2'd2;
    localparam logic [1:0] ST_TRAIL  = 2'd3;

    // byte class computed in the front end
    typedef struct packed {
        logic       space;
        logic       digit;
        logic       digit19;
        logic       hex_ok;
        logic [3:0] hex_val;
    } byte_class_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        byte_class_t cls;
    } item_t;

    function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] i);
        logic [7:0] c;
        c = 8'h00;
        case (k)
            2'd0: case (i)
                3'd0: c = "t"; 3'd1: c = "r"; 3'd2: c = "u"; 3'd3: c = "e";
                default: c = 8'h00;
            endcase
            2'd1: case (i)
                3'd0: c = "f"; 3'd1: c = "a"; 3'd2: c = "l"; 3'd3: c = "s";
                3'd4: c = "e";
                default: c = 8'h00;
            endcase
            default: case (i)
                3'd0: c = "n"; 3'd1: c = "u"; 3'd2: c = "l"; 3'd3: c = "l";
                default: c = 8'h00;
            endcase
        endcase
        return c;
    endfunction

    function automatic logic [2:0] lit_len(input logic [1:0] k);
        return (k == 2'd1) ? 3'd5 : 3'd4;
    endfunction

endpackage

[rtl/json_document_validator.sv]
// channel | direction | tdata (low bit up)          | tuser | tlast
// s_axis  | in        | data_byte[7:0]              | -     | last_byte
// m_axis  | out       | status[1:0], error_offset   | -     | -
//
// one byte per cycle sustained while no result waits on m_tready; a byte is
// registered in the two-entry queue and parsed combinationally from there, so
// the result register loads when the last byte leaves the queue.
// reset is synchronous on aresetn low and clears all document state and sets
// max_depth to 64. while a result waits on m_tready the queue keeps taking
// beats until both entries are full and then s_tready drops.
module json_document_validator #(
    parameter int STACK_DEPTH = 64,
    parameter int OFFSET_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // status[1:0], error_offset[33:2], zero fill
);
    import jdv_pkg::*;

    logic [6:0]  max_depth_reg;
    logic        q_valid, q_ready;
    item_t       q_item;
    logic [1:0]  status;
    logic [31:0] offset;

    always_ff @(posedge aclk) begin
        if (!aresetn) max_depth_reg <= 7'd64;
        else if (cfg_we) max_depth_reg <= cfg_wdata;
    end

    jdv_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_data(s_tdata), .in_last(s_tlast),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    jdv_back #(.STACK_DEPTH(STACK_DEPTH), .OFFSET_BITS(OFFSET_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn), .max_depth(max_depth_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .m_valid(m_tvalid), .m_ready(m_tready),
        .m_status(status), .m_offset(offset)
    );

    assign m_tdata = {6'd0, offset, status};
endmodule

[rtl/jdv_front.sv]
module jdv_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       in_data,
    input  logic             in_last,
    output logic             q_valid,
    input  logic             q_ready,
    output jdv_pkg::item_t   q_item
);
    import jdv_pkg::*;

    // two-entry queue towards the back end
    item_t      mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    item_t      item;
    logic       push, pop;

    always_comb begin
        item.data = in_data;
        item.last = in_last;
        item.cls.space = (in_data == 8'h20) || (in_data == 8'h09) ||
                         (in_data == 8'h0A) || (in_data == 8'h0D);
        item.cls.digit = (in_data >= "0") && (in_data <= "9");
        item.cls.digit19 = (in_data >= "1") && (in_data <= "9");
        item.cls.hex_ok = 1'b1;
        item.cls.hex_val = 4'd0;
        if (item.cls.digit) begin
            item.cls.hex_val = 4'(in_data - "0");
        end else if (in_data >= "a" && in_data <= "f") begin
            item.cls.hex_val = 4'(in_data - "a" + 8'd10);
        end else if (in_data >= "A" && in_data <= "F") begin
            item.cls.hex_val = 4'(in_data - "A" + 8'd10);
        end else begin
            item.cls.hex_ok = 1'b0;
        end
    end

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= item;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop) rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

[rtl/jdv_back.sv]
module jdv_back #(
    parameter int STACK_DEPTH = 64,
    parameter int OFFSET_BITS = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [6:0]       max_depth,
    input  logic             q_valid,
    output logic             q_ready,
    input  jdv_pkg::item_t   q_item,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_status,
    output logic [31:0]      m_offset
);
    import jdv_pkg::*;

    localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1) + 1;
    localparam logic [OFFSET_BITS-1:0] OMAX = '1;

    logic              stack_reg [STACK_DEPTH];
    // copies of the top of stack and the level below it, held beside the array
    logic              top_reg;
    logic              below_reg;
    mode_t             mode_reg, mode_next;
    logic [DW-1:0]     depth_reg, depth_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next;
    logic [15:0]       hex_reg, hex_next;
    logic [2:0]        sub_reg, sub_next;
    logic [3:0]        u8_reg, u8_next;
    logic [1:0]        lit_reg, lit_next;
    logic [1:0]        err_reg, err_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic              push_en;
    logic              pop_en;
    logic              push_bit;
    logic              out_valid_reg;
    logic [1:0]        out_status_reg;
    logic [31:0]       out_offset_reg;

    logic              step;
    logic [7:0]        b;
    byte_class_t       c;
    logic [DW-1:0]     limit;
    logic              top_obj;
    logic [OFFSET_BITS-1:0] endpos;

    assign q_ready = !out_valid_reg || m_ready;
    assign step    = q_valid && q_ready;
    assign b       = q_item.data;
    assign c       = q_item.cls;
    assign m_valid  = out_valid_reg;
    assign m_status = out_status_reg;
    assign m_offset = out_offset_reg;

    assign limit = ({{(DW > 7 ? DW-7 : 0){1'b0}}, max_depth} < DW'(STACK_DEPTH)) ?
                   DW'(max_depth) : DW'(STACK_DEPTH);
    assign top_obj = (depth_reg == '0) ? 1'b0 : top_reg;
    assign endpos = (off_reg == OMAX) ? OMAX : off_reg + 1'b1;

    function automatic logic [OFFSET_BITS-1:0] back_off(
        input logic [OFFSET_BITS-1:0] p, input logic [2:0] k);
        return (p >= OFFSET_BITS'(k)) ? p - OFFSET_BITS'(k) : '0;
    endfunction

    always_comb begin
        logic [1:0]  n;
        logic [7:0]  lo, hi;
        logic        ok;
        logic [15:0] h;
        logic        redo;
        mode_t       m;
        mode_next  = mode_reg;
        depth_next = depth_reg;
        hex_next   = hex_reg;
        sub_next   = sub_reg;
        u8_next    = u8_reg;
        lit_next   = lit_reg;
        err_next   = err_reg;
        pos_next   = pos_reg;
        push_en    = 1'b0;
        pop_en     = 1'b0;
        push_bit   = 1'b0;
        n = 2'd0; lo = 8'h80; hi = 8'hBF; ok = 1'b0; h = 16'd0; redo = 1'b0;
        m = mode_reg;
        // numbers ending and open array re-enter as a value or after-state
        case (mode_reg)
            M_OPEN_ARR: if (!c.space && b != "]") begin
                m = M_VALUE;
            end
            N_ZERO, N_INT, N_FRAC, N_EXPDIG: begin
                redo = !((mode_reg != N_ZERO && c.digit) ||
                         ((mode_reg == N_ZERO || mode_reg == N_INT) && b == ".") ||
                         (mode_reg != N_EXPDIG && (b == "e" || b == "E")));
                if (redo) m = (depth_reg != '0) ? M_AFTER : M_DONE;
            end
            default: m = mode_reg;
        endcase
        mode_next = m;

        case (m)
            M_VALUE: if (!c.space) begin
                if (b == "{" || b == "[") begin
                    if (depth_reg >= limit) begin
                        err_next = ST_DEPTH; pos_next = off_reg; mode_next = M_ERROR;
                    end else begin
                        push_en = 1'b1; push_bit = (b == "{");
                        depth_next = depth_reg + 1'b1;
                        mode_next = (b == "{") ? M_OPEN_OBJ : M_OPEN_ARR;
                    end
                end else if (b == 8'h22) begin
                    lit_next = 2'd0; mode_next = M_STR;
                end else if (b == "t" || b == "f" || b == "n") begin
                    lit_next = (b == "t") ? 2'd0 : (b == "f") ? 2'd1 : 2'd2;
                    sub_next = 3'd1; mode_next = M_LIT;
                end else if (b == "-") begin
                    mode_next = N_SIGN;
                end else if (b == "0") begin
                    mode_next = N_ZERO;
                end else if (c.digit19) begin
                    mode_next = N_INT;
                end else begin
                    err_next = ST_SYNTAX; pos_next = off_reg; mode_next = M_ERROR;
                end
            end
            M_OPEN_ARR: if (!c.space) begin
                pop_en = 1'b1;
                depth_next = depth_reg - 1'b1;
                mode_next = (depth_reg > DW'(1)) ? M_AFTER : M_DONE;
            end
            M_OPEN_OBJ, M_KEY: if (!c.space) begin
                if (m == M_OPEN_OBJ && b == "}") begin
                    pop_en = 1'b1;
                    depth_next = depth_reg - 1'b1;
                    mode_next = (depth_reg > DW'(1)) ? M_AFTER : M_DONE;
                end else if (b == 8'h22) begin
                    lit_next = 2'd1; mode_next = M_STR;
                end else begin
                    err_next = ST_SYNTAX; pos_next = off_reg; mode_next = M_ERROR;
                end
            end
            M_COLON: if (!c.space) begin
                if (b == ":") mode_next = M_VALUE;
                else begin
                    err_next = ST_SYNTAX; pos_next = off_reg; mode_next = M_ERROR;
                end
            end
            M_AFTER: if (!c.space) begin
                if (b == ",") begin
                    mode_next = top_obj ? M_KEY : M_VALUE;
                end else if (b == (top_obj ? 8'h7D : 8'h5D)) begin
                    if (depth_reg != '0) begin
                        pop_en = 1'b1;
                        depth_next = depth_reg - 1'b1;
                    end
                    mode_next = (depth_reg > DW'(1)) ? M_AFTER : M_DONE;
                end else begin
                    err_next = ST_SYNTAX; pos_next = off_reg; mode_next = M_ERROR;
                end
            end
            M_DONE: if (!c.space) begin
                err_next = ST_TRAIL; pos_next = off_reg; mode_next = M_ERROR;
            end
            M_STR: begin
                if (b == 8'h22) begin
                    mode_next = lit_reg[0] ? M_COLON :
                                (depth_reg != '0) ? M_AFTER : M_DONE;
                end else if (b == 8'h5C) begin
                    mode_next = M_ESC;
                end else if (b < 8'h20) begin
                    err_next = ST_SYNTAX; pos_next = off_reg; mode_next = M_ERROR;
                end else if (b >= 8'h80) begin
                    sub_next = 3'd1; mode_next = M_UTF8;
                    if (b >= 8'hC2 && b <= 8'hDF) u8_next = 4'd0;
                    else if (b >= 8'hE0 && b <= 8'hEF)
                        u8_next = {2'd1, (b == 8'hE0) ? 2'd1 : (b == 8'hED) ? 2'd2 : 2'd0};
                    else if (b >= 8'hF0 && b <= 8'hF4)
                        u8_next = {2'd2, (b == 8'hF0) ? 2'd1 : (b == 8'hF4) ? 2'd2 : 2'd0};
                    else begin
                        sub_next = sub_reg;
                        err_next = ST_SYNTAX; pos_next = off_reg; mode_next = M_ERROR;
                    end
                end
            end
            M_ESC: begin
                if (b == 8'h22 || b == 8'h5C || b == "/" || b == "b" || b == "f" ||
                    b == "n" || b == "r" || b == "t") begin
                    mode_next = M_STR;
                end else if (b == "u") begin
                    mode_next = M_HEX; sub_next = 3'd0; hex_next = 16'd0;
                end else begin
                    err_next = ST_SYNTAX; pos_next = off_reg; mode_next = M_ERROR;
                end
            end
            M_HEX, M_LO_HEX: begin
                if (!c.hex_ok) begin
                    err_next = ST_SYNTAX; pos_next = back_off(off_reg, sub_reg);
                    mode_next = M_ERROR;
                end else begin
                    h = {hex_reg[11:0], c.hex_val};
                    hex_next = h;
                    sub_next = sub_reg + 3'd1;
                    if (m == M_HEX && sub_reg == 3'd3) begin
                        if (h >= 16'hD800 && h <= 16'hDBFF) begin
                            mode_next = M_LO_BS; sub_next = 3'd0;
                        end else if (h >= 16'hDC00 && h <= 16'hDFFF) begin
                            err_next = ST_SYNTAX; pos_next = back_off(off_reg, 3'd3);
                            mode_next = M_ERROR;
                        end else begin
                            mode_next = M_STR;
                        end
                    end else if (m == M_LO_HEX && sub_reg == 3'd5) begin
                        if (h >= 16'hDC00 && h <= 16'hDFFF) mode_next = M_STR;
                        else begin
                            err_next = ST_SYNTAX; pos_next = back_off(off_reg, 3'd5);
                            mode_next = M_ERROR;
                        end
                    end
                end
            end
            M_LO_BS: begin
                if (b == 8'h5C) begin
                    mode_next = M_LO_U; sub_next = 3'd1;
                end else begin
                    err_next = ST_SYNTAX; pos_next = off_reg; mode_next = M_ERROR;
                end
            end
            M_LO_U: begin
                if (b == "u") begin
                    mode_next = M_LO_HEX; sub_next = 3'd2; hex_next = 16'd0;
                end else begin
                    err_next = ST_SYNTAX; pos_next = back_off(off_reg, 3'd1);
                    mode_next = M_ERROR;
                end
            end
            M_UTF8: begin
                n = u8_reg[3:2];
                if (sub_reg == 3'd1) begin
                    lo = (u8_reg[1:0] == 2'd1) ? ((n == 2'd1) ? 8'hA0 : 8'h90) : 8'h80;
                    hi = (u8_reg[1:0] == 2'd2) ? ((n == 2'd1) ? 8'h9F : 8'h8F) : 8'hBF;
                    ok = (b >= lo) && (b <= hi);
                end else begin
                    ok = (b[7:6] == 2'b10);
                end
                if (!ok) begin
                    err_next = ST_SYNTAX; pos_next = back_off(off_reg, sub_reg);
                    mode_next = M_ERROR;
                end else begin
                    sub_next = sub_reg + 3'd1;
                    if (sub_reg + 3'd1 >= 3'(n) + 3'd2) mode_next = M_STR;
                end
            end
            M_LIT: begin
                if (sub_reg < lit_len(lit_reg) && b == lit_char(lit_reg, sub_reg)) begin
                    sub_next = sub_reg + 3'd1;
                    if (sub_reg + 3'd1 >= lit_len(lit_reg))
                        mode_next = (depth_reg != '0) ? M_AFTER : M_DONE;
                end else begin
                    err_next = ST_SYNTAX; pos_next = back_off(off_reg, sub_reg);
                    mode_next = M_ERROR;
                end
            end
            N_SIGN: begin
                if (b == "0") mode_next = N_ZERO;
                else if (c.digit19) mode_next = N_INT;
                else begin
                    err_next = ST_SYNTAX; pos_next = off_reg; mode_next = M_ERROR;
                end
            end
            N_ZERO, N_INT, N_FRAC: begin
                if (b == ".") mode_next = N_DOT;
                else if (b == "e" || b == "E") mode_next = N_EXP;
            end
            N_DOT, N_EXPSIGN: begin
                if (c.digit) mode_next = (m == N_DOT) ? N_FRAC : N_EXPDIG;
                else begin
                    err_next = ST_SYNTAX; pos_next = off_reg; mode_next = M_ERROR;
                end
            end
            N_EXP: begin
                if (b == "+" || b == "-") mode_next = N_EXPSIGN;
                else if (c.digit) mode_next = N_EXPDIG;
                else begin
                    err_next = ST_SYNTAX; pos_next = off_reg; mode_next = M_ERROR;
                end
            end
            default: mode_next = m;
        endcase

        // end of document checks run on the state after this beat
        if (q_item.last) begin
            case (mode_next)
                M_DONE, M_ERROR: ;
                N_ZERO, N_INT, N_FRAC, N_EXPDIG: if (depth_next != '0) begin
                    err_next = ST_SYNTAX; pos_next = endpos;
                end
                M_LIT, M_HEX, M_LO_BS, M_LO_U, M_LO_HEX, M_UTF8: begin
                    err_next = ST_SYNTAX; pos_next = back_off(endpos, sub_next);
                end
                default: begin
                    err_next = ST_SYNTAX; pos_next = endpos;
                end
            endcase
        end
        off_next = endpos;
    end

    // entries are read only after they are written, so no reset here
    always_ff @(posedge aclk) begin
        if (step && push_en) begin
            stack_reg[SW'(depth_reg)] <= push_bit;
            top_reg <= push_bit;
            below_reg <= top_reg;
        end else if (step && pop_en) begin
            top_reg <= below_reg;
            below_reg <= stack_reg[SW'(depth_reg - DW'(3))];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_VALUE;
            depth_reg <= '0;
            off_reg <= '0;
            hex_reg <= '0;
            sub_reg <= '0;
            u8_reg <= '0;
            lit_reg <= '0;
            err_reg <= ST_VALID;
            pos_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (step && q_item.last) out_valid_reg <= 1'b1;
            else if (m_valid && m_ready) out_valid_reg <= 1'b0;
            if (step) begin
                if (q_item.last) begin
                    out_status_reg <= err_next;
                    if (err_next == ST_VALID) out_offset_reg <= '0;
                    else if (OFFSET_BITS > 32 && (pos_next >> 32) != '0)
                        out_offset_reg <= '1;
                    else out_offset_reg <= 32'(pos_next);
                    mode_reg <= M_VALUE;
                    depth_reg <= '0;
                    off_reg <= '0;
                    hex_reg <= '0;
                    sub_reg <= '0;
                    u8_reg <= '0;
                    lit_reg <= '0;
                    err_reg <= ST_VALID;
                    pos_reg <= '0;
                end else begin
                    mode_reg <= mode_next;
                    depth_reg <= depth_next;
                    off_reg <= off_next;
                    hex_reg <= hex_next;
                    sub_reg <= sub_next;
                    u8_reg <= u8_next;
                    lit_reg <= lit_next;
                    err_reg <= err_next;
                    pos_reg <= pos_next;
                end
            end
        end
    end
endmodule
